@@ rtl/core/bcd_pkg.sv @@
// Shared types and opcode constants for the bounded circular deque.
`timescale 1ns / 1ps

package bcd_pkg;

   localparam int CAP_W = 11;
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   localparam logic [2:0] OP_INSERT_FRONT = 3'd0;
   localparam logic [2:0] OP_INSERT_BACK  = 3'd1;
   localparam logic [2:0] OP_REMOVE_FRONT = 3'd2;
   localparam logic [2:0] OP_REMOVE_BACK  = 3'd3;
   localparam logic [2:0] OP_QUERY        = 3'd4;

   localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic signed [31:0] front_value;
      logic signed [31:0] rear_value;
      logic               empty_res;
      logic               full_res;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic exec;   // apply the accepted transaction to pointers, count and store
      logic read;   // read front and rear into the result register
   } cmd_type;

endpackage

@@ rtl/core/bounded_circular_deque.sv @@
// Top level of the bounded circular deque: controller plus datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data  (opcode, value)
//   rsp      out        rsp_valid / rsp_stall  rsp_data  (ok, front, rear, empty, full)
//   csr      in         csr_we                 csr_wdata (capacity)
//
// Each transaction updates pointers, count and the ring store on the accept edge; in ST_READ,
// once the result register is free, it reads front and rear from the store's registered ports.
// A new transaction is stalled until that write-then-read of the store is through.
// Synchronous active-high reset empties the deque and sets capacity to 1024;
// store contents are not cleared.
// A stalled result is held while one more transaction is accepted; its read waits.
`timescale 1ns / 1ps

module bounded_circular_deque
   import bcd_pkg::*;
#(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   cmd_type cmd;

   bcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bcd_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/core/bcd_ctrl.sv @@
// Controller state machine: input handshake, store read slot and result valid.
`timescale 1ns / 1ps

module bcd_ctrl
   import bcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.exec     = 1'b0;
      cmd.read     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.exec = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // hold the read until the result register is free
            if (!rsp_valid_ff || rsp_take) begin
               cmd.read     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ))
      else $error("result valid rose without a store read");

   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_READ))
      else $error("accepted transaction did not move to read");

   a_no_exec_and_read: assert property (@(posedge clock) disable iff (reset)
      !(cmd.exec && cmd.read))
      else $error("exec and read issued together");

endmodule

@@ rtl/core/bcd_datapath.sv @@
// Datapath: ring store, front/back pointers, entry count, capacity and result register.
`timescale 1ns / 1ps

module bcd_datapath
   import bcd_pkg::*;
#(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
)(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  req_type          req_data,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata,
   output rsp_type          rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(DEPTH);

   logic [DATA_WIDTH-1:0] ring_mem [DEPTH];

   logic [IDX_W-1:0]      front_ff, front_in;
   logic [IDX_W-1:0]      back_ff, back_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CAP_W-1:0]      cap_ff;
   logic                  ok_ff, ok_in;

   logic [DATA_WIDTH-1:0] rd_front_ff, rd_rear_ff;
   logic                  ok_out_ff, empty_out_ff, full_out_ff;

   logic [IDX_W-1:0]      front_prev, front_next, back_prev, back_next;
   logic [CMP_W-1:0]      cap_ext, eff_cap, count_ext;
   logic                  can_insert, can_remove, is_empty, is_full;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic signed [63:0]    front_wide, rear_wide;

   assign front_prev = (front_ff == '0) ? IDX_LAST : front_ff - 1'b1;
   assign front_next = (front_ff == IDX_LAST) ? '0 : front_ff + 1'b1;
   assign back_prev  = (back_ff == '0) ? IDX_LAST : back_ff - 1'b1;
   assign back_next  = (back_ff == IDX_LAST) ? '0 : back_ff + 1'b1;

   // capacity above the store depth saturates at the depth
   assign cap_ext    = CMP_W'(cap_ff);
   assign eff_cap    = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
   assign count_ext  = CMP_W'(count_ff);
   assign can_insert = count_ext < eff_cap;
   assign can_remove = (count_ff != '0);
   assign is_empty   = (count_ff == '0);
   assign is_full    = count_ext >= eff_cap;

   assign wr_data = DATA_WIDTH'(64'(req_data.value));

   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      ok_in    = ok_ff;
      wr_en    = 1'b0;
      wr_addr  = back_ff;
      if (cmd.exec) begin
         ok_in = 1'b1;
         unique case (req_data.opcode)
            OP_INSERT_FRONT: begin
               if (can_insert) begin
                  front_in = front_prev;
                  wr_en    = 1'b1;
                  wr_addr  = front_prev;
                  count_in = count_ff + 1'b1;
               end else begin
                  ok_in = 1'b0;
               end
            end
            OP_INSERT_BACK: begin
               if (can_insert) begin
                  back_in  = back_next;
                  wr_en    = 1'b1;
                  wr_addr  = back_ff;
                  count_in = count_ff + 1'b1;
               end else begin
                  ok_in = 1'b0;
               end
            end
            OP_REMOVE_FRONT: begin
               if (can_remove) begin
                  front_in = front_next;
                  count_in = count_ff - 1'b1;
               end else begin
                  ok_in = 1'b0;
               end
            end
            OP_REMOVE_BACK: begin
               if (can_remove) begin
                  back_in  = back_prev;
                  count_in = count_ff - 1'b1;
               end else begin
                  ok_in = 1'b0;
               end
            end
            default: begin
               // query and unused codes leave the state alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
      if (cmd.read) begin
         ok_out_ff    <= ok_ff;
         empty_out_ff <= is_empty;
         full_out_ff  <= is_full;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      if (cmd.read) begin
         rd_front_ff <= ring_mem[front_ff];
         rd_rear_ff  <= ring_mem[back_prev];
      end
   end

   assign front_wide = 64'($signed(rd_front_ff));
   assign rear_wide  = 64'($signed(rd_rear_ff));

   assign rsp_data.ok          = ok_out_ff;
   assign rsp_data.front_value = empty_out_ff ? EMPTY_VALUE : front_wide[31:0];
   assign rsp_data.rear_value  = empty_out_ff ? EMPTY_VALUE : rear_wide[31:0];
   assign rsp_data.empty_res   = empty_out_ff;
   assign rsp_data.full_res    = full_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= DEPTH_C)
      else $error("entry count exceeds store depth");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && can_insert &&
       (req_data.opcode == OP_INSERT_FRONT || req_data.opcode == OP_INSERT_BACK))
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("accepted insert did not advance the count");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.read && count_ff == '0) |=> (rsp_data.empty_res &&
       rsp_data.front_value == EMPTY_VALUE && rsp_data.rear_value == EMPTY_VALUE))
      else $error("empty deque result not flagged");

endmodule
